[rtl/core/tllr_pkg.sv]
package tllr_pkg;

    // Fixed field widths
    localparam int TLLR_FLAG_W    = 8;
    localparam int TLLR_GRP_W     = 2;
    localparam int TLLR_SEC_W     = 8;
    localparam int TLLR_HOLD_W    = 16;
    localparam int TLLR_TICK_W    = 20;
    localparam int TLLR_REQ_W     = 2;
    localparam int TLLR_CFG_IDX_W = 3;
    localparam int TLLR_CFG_DAT_W = 20;

    // Default geometry
    localparam int TLLR_GROUPS          = 2;
    localparam int TLLR_LANES_PER_GROUP = 4;

    // Register indexes
    localparam logic [TLLR_CFG_IDX_W-1:0] CFG_RESYNC_ENABLE   = 3'd0;
    localparam logic [TLLR_CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 3'd1;
    localparam logic [TLLR_CFG_IDX_W-1:0] CFG_RESET_HOLD      = 3'd2;
    localparam logic [TLLR_CFG_IDX_W-1:0] CFG_RESET_TIMEOUT   = 3'd3;
    localparam logic [TLLR_CFG_IDX_W-1:0] CFG_RESETS_REQUIRED = 3'd4;

    // Register reset values
    localparam logic                      RST_RESYNC_ENABLE   = 1'b1;
    localparam logic [TLLR_SEC_W-1:0]     RST_CHECK_INTERVAL  = 8'd2;
    localparam logic [TLLR_HOLD_W-1:0]    RST_RESET_HOLD      = 16'd200;
    localparam logic [TLLR_TICK_W-1:0]    RST_RESET_TIMEOUT   = 20'd100000;
    localparam logic [TLLR_REQ_W-1:0]     RST_RESETS_REQUIRED = 2'd2;

    localparam logic [TLLR_SEC_W-1:0]     SEC_MAX = 8'd255;

    typedef struct packed {
        logic                   resync_enable;
        logic [TLLR_SEC_W-1:0]  check_interval_seconds;
        logic [TLLR_HOLD_W-1:0] reset_hold_ticks;
        logic [TLLR_TICK_W-1:0] reset_timeout_ticks;
        logic [TLLR_REQ_W-1:0]  resets_required;
    } cfg_t;

    typedef struct packed {
        logic                   second_strobe;
        logic [TLLR_FLAG_W-1:0] lock_lost_flags;
        logic [TLLR_FLAG_W-1:0] reset_done_flags;
        logic                   force_reset;
    } in_item_t;

    typedef struct packed {
        logic [TLLR_GRP_W-1:0] reset_lines;
        logic                  realign_pulse;
        logic                  lock_loss_report;
        logic                  reset_failed;
        logic                  recovering;
        logic [TLLR_GRP_W-1:0] lost_groups;
        logic                  busy_res;
    } out_item_t;

endpackage

[rtl/core/transceiver_lock_loss_recovery_top.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   second_strobe, lock_lost_flags,
//                                            reset_done_flags, force_reset
// output    out        out_valid / out_ready reset_lines, realign_pulse, lock_loss_report,
//                                            reset_failed, recovering, lost_groups, busy_res
// config    in         cfg_we                cfg_index, cfg_data (write only)
//
// One request per clock while the output is not stalled; each accepted request passes the
// input register, then the state update into the result register.
// Reset loads the registers with their defaults and clears all recovery state.
// A stalled output holds its result; the input register keeps its request, or takes one
// more if it is empty, and holds in_ready low until the result is taken.
module transceiver_lock_loss_recovery_top #(
    parameter int GROUPS          = tllr_pkg::TLLR_GROUPS,
    parameter int LANES_PER_GROUP = tllr_pkg::TLLR_LANES_PER_GROUP
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [tllr_pkg::TLLR_CFG_IDX_W-1:0] cfg_index,
    input  logic [tllr_pkg::TLLR_CFG_DAT_W-1:0] cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                second_strobe,
    input  logic [tllr_pkg::TLLR_FLAG_W-1:0]    lock_lost_flags,
    input  logic [tllr_pkg::TLLR_FLAG_W-1:0]    reset_done_flags,
    input  logic                                force_reset,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tllr_pkg::TLLR_GRP_W-1:0]     reset_lines,
    output logic                                realign_pulse,
    output logic                                lock_loss_report,
    output logic                                reset_failed,
    output logic                                recovering,
    output logic [tllr_pkg::TLLR_GRP_W-1:0]     lost_groups,
    output logic                                busy_res
);
    import tllr_pkg::*;

    cfg_t      cfg;
    in_item_t  up_item;
    in_item_t  stage_item;
    logic      stage_valid;
    logic      stage_ready;
    out_item_t res_item;

    // Pack the input fields into one request
    assign up_item.second_strobe    = second_strobe;
    assign up_item.lock_lost_flags  = lock_lost_flags;
    assign up_item.reset_done_flags = reset_done_flags;
    assign up_item.force_reset      = force_reset;

    // Hold the configuration registers
    tllr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Register the incoming request
    tllr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_item  (up_item),
        .dn_valid (stage_valid),
        .dn_ready (stage_ready),
        .dn_item  (stage_item)
    );

    // Advance the recovery sequencer and register the result
    tllr_ctrl #(
        .GROUPS          (GROUPS),
        .LANES_PER_GROUP (LANES_PER_GROUP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (stage_valid),
        .in_ready  (stage_ready),
        .in_item   (stage_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (res_item)
    );

    // Unpack the result onto its ports
    assign reset_lines      = res_item.reset_lines;
    assign realign_pulse    = res_item.realign_pulse;
    assign lock_loss_report = res_item.lock_loss_report;
    assign reset_failed     = res_item.reset_failed;
    assign recovering       = res_item.recovering;
    assign lost_groups      = res_item.lost_groups;
    assign busy_res         = res_item.busy_res;

endmodule

[rtl/core/tllr_cfg.sv]
module tllr_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tllr_pkg::TLLR_CFG_IDX_W-1:0]   cfg_index,
    input  logic [tllr_pkg::TLLR_CFG_DAT_W-1:0]   cfg_data,
    output tllr_pkg::cfg_t                        cfg
);
    import tllr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resync_enable          <= RST_RESYNC_ENABLE;
            cfg_reg.check_interval_seconds <= RST_CHECK_INTERVAL;
            cfg_reg.reset_hold_ticks       <= RST_RESET_HOLD;
            cfg_reg.reset_timeout_ticks    <= RST_RESET_TIMEOUT;
            cfg_reg.resets_required        <= RST_RESETS_REQUIRED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESYNC_ENABLE:   cfg_reg.resync_enable <= cfg_data[0];
                CFG_CHECK_INTERVAL:  cfg_reg.check_interval_seconds <= cfg_data[TLLR_SEC_W-1:0];
                CFG_RESET_HOLD:      cfg_reg.reset_hold_ticks <= cfg_data[TLLR_HOLD_W-1:0];
                CFG_RESET_TIMEOUT:   cfg_reg.reset_timeout_ticks <= cfg_data[TLLR_TICK_W-1:0];
                CFG_RESETS_REQUIRED: cfg_reg.resets_required <= cfg_data[TLLR_REQ_W-1:0];
                default:             ; // drop writes to unmapped indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/tllr_in_stage.sv]
module tllr_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  tllr_pkg::in_item_t   up_item,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output tllr_pkg::in_item_t   dn_item
);
    import tllr_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Take a new request when empty or when the held one moves on this cycle
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up_item;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

[rtl/core/tllr_ctrl.sv]
module tllr_ctrl #(
    parameter int GROUPS          = tllr_pkg::TLLR_GROUPS,
    parameter int LANES_PER_GROUP = tllr_pkg::TLLR_LANES_PER_GROUP
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tllr_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tllr_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tllr_pkg::out_item_t  out_item
);
    import tllr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HOLD = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    localparam logic [TLLR_GRP_W-1:0] ALL_GROUPS = TLLR_GRP_W'((1 << GROUPS) - 1);

    phase_t                 phase_reg, phase_next;
    logic [TLLR_SEC_W-1:0]  secs_reg, secs_next;
    logic [TLLR_TICK_W-1:0] tick_reg, tick_next;
    logic [TLLR_REQ_W-1:0]  rem_reg, rem_next;
    logic                   reported_reg, reported_next;
    logic [TLLR_GRP_W-1:0]  target_reg, target_next;
    logic                   forced_reg, forced_next;
    logic                   out_valid_reg;
    out_item_t              out_item_reg, out_item_next;

    logic                   take;
    logic [TLLR_SEC_W-1:0]  secs_inc;
    logic [TLLR_REQ_W-1:0]  req_count;
    logic [TLLR_GRP_W-1:0]  lost;
    logic [TLLR_GRP_W-1:0]  active_cur;
    logic [TLLR_GRP_W-1:0]  active_new;
    logic                   all_ok;
    logic                   start;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign req_count = (cfg.resets_required == '0) ? TLLR_REQ_W'(1) : cfg.resets_required;

    assign secs_inc = (in_item.second_strobe && secs_reg != SEC_MAX) ? secs_reg + 1'b1 : secs_reg;

    assign active_cur = forced_reg ? ALL_GROUPS : (target_reg & ALL_GROUPS);
    assign active_new = forced_next ? ALL_GROUPS : (target_next & ALL_GROUPS);

    // Per-group lane reduction
    always_comb
    begin
        lost   = '0;
        all_ok = 1'b1;
        for (int g = 0; g < GROUPS; g++)
        begin
            lost[g] = |in_item.lock_lost_flags[g*LANES_PER_GROUP +: LANES_PER_GROUP];
            if (active_cur[g] && !(&in_item.reset_done_flags[g*LANES_PER_GROUP +: LANES_PER_GROUP]))
            begin
                all_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        secs_next     = secs_inc;
        tick_next     = tick_reg;
        rem_next      = rem_reg;
        reported_next = reported_reg;
        target_next   = target_reg;
        forced_next   = forced_reg;
        start         = 1'b0;
        out_item_next = '0;

        unique case (phase_reg)
            PH_HOLD:
            begin
                if (tick_reg >= TLLR_TICK_W'(cfg.reset_hold_ticks))
                begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
                else
                begin
                    out_item_next.reset_lines = active_cur;
                    tick_next = tick_reg + 1'b1;
                end
            end
            PH_WAIT:
            begin
                if (all_ok || tick_reg >= cfg.reset_timeout_ticks)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    if (forced_reg)
                    begin
                        if (all_ok)
                        begin
                            reported_next = 1'b0;
                            out_item_next.realign_pulse = 1'b1;
                        end
                        else
                        begin
                            out_item_next.reset_failed = 1'b1;
                        end
                        forced_next = 1'b0;
                    end
                    else if (all_ok)
                    begin
                        rem_next = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
                        if (rem_next == '0)
                        begin
                            reported_next = 1'b0;
                            out_item_next.realign_pulse = 1'b1;
                        end
                    end
                    else
                    begin
                        rem_next = req_count;
                        out_item_next.reset_failed = 1'b1;
                    end
                end
                else
                begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (in_item.force_reset)
                begin
                    forced_next = 1'b1;
                    start       = 1'b1;
                end
                else if (cfg.resync_enable && secs_inc > cfg.check_interval_seconds)
                begin
                    secs_next = '0;
                    if (rem_reg == '0 && lost != '0)
                    begin
                        target_next = lost;
                        rem_next    = req_count;
                        if (!reported_reg)
                        begin
                            reported_next = 1'b1;
                            out_item_next.lock_loss_report = 1'b1;
                        end
                    end
                    start = (rem_next != '0);
                end
                if (start)
                begin
                    phase_next = PH_HOLD;
                    tick_next  = TLLR_TICK_W'(1);
                    out_item_next.reset_lines = active_new;
                end
            end
        endcase

        out_item_next.recovering  = (rem_next != '0);
        out_item_next.lost_groups = target_next;
        out_item_next.busy_res    = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            secs_reg      <= '0;
            tick_reg      <= '0;
            rem_reg       <= '0;
            reported_reg  <= 1'b0;
            target_reg    <= '0;
            forced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg    <= phase_next;
                secs_reg     <= secs_next;
                tick_reg     <= tick_next;
                rem_reg      <= rem_next;
                reported_reg <= reported_next;
                target_reg   <= target_next;
                forced_reg   <= forced_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
